FILE: hw/rtl/ipvf_pkg.sv
// Shared types and constants of the IPv4 ingress filter.
package ipvf_pkg;

	localparam int unsigned MAX_FRAME_BYTES    = 1518;
	localparam int unsigned REPLY_BUFFER_BYTES = 2048;

	localparam int unsigned COUNT_W     = 14;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;

	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_MIN_INTERVAL = 8'd1;

	typedef enum logic [4:0] {
		VERDICT_ARP           = 5'd0,
		VERDICT_OTHER_ETYPE   = 5'd1,
		VERDICT_RUNT          = 5'd2,
		VERDICT_OVERSIZED     = 5'd3,
		VERDICT_OPTIONS       = 5'd4,
		VERDICT_BAD_CHECKSUM  = 5'd5,
		VERDICT_FRAGMENT      = 5'd6,
		VERDICT_BAD_SOURCE    = 5'd7,
		VERDICT_NOT_FOR_US    = 5'd8,
		VERDICT_BAD_PROTOCOL  = 5'd9,
		VERDICT_UDP_MALFORMED = 5'd10,
		VERDICT_UDP_DELIVER   = 5'd11,
		VERDICT_TCP_DELIVER   = 5'd12,
		VERDICT_TCP_EMPTY     = 5'd13,
		VERDICT_ICMP_IGNORED  = 5'd14,
		VERDICT_ICMP_LIMITED  = 5'd15,
		VERDICT_ECHO_REPLY    = 5'd16
	} verdict_e;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        end_of_frame;
		logic [63:0] now_ticks;
	} in_word_t;

	typedef struct packed {
		verdict_e           verdict;
		logic [31:0]        source_address;
		logic [15:0]        source_port;
		logic [15:0]        dest_port;
		logic [COUNT_W-1:0] payload_length;
	} out_word_t;

	// Fields captured from one frame, byte count included.
	typedef struct packed {
		logic [COUNT_W-1:0] len;
		logic [15:0]        ether_type;
		logic [7:0]         version_ihl;
		logic [15:0]        total_length;
		logic [15:0]        frag_flags;
		logic [7:0]         time_to_live;
		logic [7:0]         protocol_number;
		logic [31:0]        src_addr;
		logic [31:0]        dst_addr;
		logic [63:0]        l4_header;
		logic [16:0]        header_sum;
	} frame_info_t;

	typedef struct packed {
		out_word_t word;
		logic      echo_taken;
	} judge_result_t;

endpackage

FILE: hw/rtl/ipvf_capture.sv
// Per-byte header capture and running IPv4 header checksum.
module ipvf_capture import ipvf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_word_t    word,
	output frame_info_t frame_next
);

	localparam logic [COUNT_W-1:0] POS_ETYPE_HI = 14'd12;
	localparam logic [COUNT_W-1:0] POS_ETYPE_LO = 14'd13;
	localparam logic [COUNT_W-1:0] POS_IP_FIRST = 14'd14;
	localparam logic [COUNT_W-1:0] POS_LEN_HI   = 14'd16;
	localparam logic [COUNT_W-1:0] POS_LEN_LO   = 14'd17;
	localparam logic [COUNT_W-1:0] POS_FRAG_HI  = 14'd20;
	localparam logic [COUNT_W-1:0] POS_FRAG_LO  = 14'd21;
	localparam logic [COUNT_W-1:0] POS_TTL      = 14'd22;
	localparam logic [COUNT_W-1:0] POS_PROTO    = 14'd23;
	localparam logic [COUNT_W-1:0] POS_SRC      = 14'd26;
	localparam logic [COUNT_W-1:0] POS_DST      = 14'd30;
	localparam logic [COUNT_W-1:0] POS_L4_FIRST = 14'd34;
	localparam logic [COUNT_W-1:0] POS_L4_END   = 14'd42;

	frame_info_t cur_q;

	always_comb begin
		logic [COUNT_W-1:0] pos;
		logic [7:0]         b;
		logic [17:0]        s;
		frame_next = cur_q;
		pos        = cur_q.len;
		b          = word.frame_byte;
		s          = '0;
		if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) begin
			frame_next.ether_type = {cur_q.ether_type[7:0], b};
		end
		if (pos >= POS_IP_FIRST && pos < POS_L4_FIRST) begin
			// even offsets carry the high byte of a 16-bit header word
			s = {1'b0, cur_q.header_sum} + (pos[0] ? {10'b0, b} : {2'b0, b, 8'b0});
			if (s > 18'h0FFFF) begin
				s = {2'b0, s[15:0]} + 18'd1;
			end
			frame_next.header_sum = s[16:0];
			if (pos == POS_IP_FIRST) begin
				frame_next.version_ihl = b;
			end else if (pos == POS_LEN_HI || pos == POS_LEN_LO) begin
				frame_next.total_length = {cur_q.total_length[7:0], b};
			end else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO) begin
				frame_next.frag_flags = {cur_q.frag_flags[7:0], b};
			end else if (pos == POS_TTL) begin
				frame_next.time_to_live = b;
			end else if (pos == POS_PROTO) begin
				frame_next.protocol_number = b;
			end else if (pos >= POS_SRC && pos < POS_DST) begin
				frame_next.src_addr = {cur_q.src_addr[23:0], b};
			end else if (pos >= POS_DST) begin
				frame_next.dst_addr = {cur_q.dst_addr[23:0], b};
			end
		end
		if (pos >= POS_L4_FIRST && pos < POS_L4_END) begin
			frame_next.l4_header = {cur_q.l4_header[55:0], b};
		end
		if (cur_q.len != COUNT_MAX) begin
			frame_next.len = cur_q.len + 14'd1;
		end
	end

	// Clear on the last byte so the next frame starts from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			if (word.end_of_frame) begin
				cur_q <= '0;
			end else begin
				cur_q <= frame_next;
			end
		end
	end

endmodule

FILE: hw/rtl/ipvf_judge.sv
// Verdict logic for one completed frame.
module ipvf_judge import ipvf_pkg::*; (
	input  frame_info_t   info,
	input  logic [63:0]   now_ticks,
	input  logic [31:0]   own_address,
	input  logic [63:0]   echo_min_interval,
	input  logic [63:0]   last_echo_tick,
	output judge_result_t result
);

	localparam logic [16:0] ETH_HDR_BYTES   = 17'd14;
	localparam logic [16:0] IP_END_BYTES    = 17'd34;
	localparam logic [15:0] IP_HDR_BYTES    = 16'd20;
	localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
	localparam logic [15:0] ICMP_MIN_TOTAL  = 16'd28;
	localparam logic [COUNT_W-1:0] LEN_ETH  = 14'd14;
	localparam logic [COUNT_W-1:0] LEN_IP   = 14'd34;
	localparam logic [COUNT_W-1:0] LEN_UDP  = 14'd42;
	localparam logic [COUNT_W-1:0] LEN_MAX  = COUNT_W'(MAX_FRAME_BYTES);
	localparam logic [16:0] REPLY_LIMIT     = 17'(REPLY_BUFFER_BYTES);
	localparam logic [15:0] FRAG_MF_MASK    = 16'h2000;
	localparam logic [15:0] FRAG_OFF_MASK   = 16'h1FFF;
	localparam logic [3:0]  IP_VERSION      = 4'd4;
	localparam logic [3:0]  IP_IHL_PLAIN    = 4'd5;
	localparam logic [7:0]  LOOPBACK_NET    = 8'd127;
	localparam logic [3:0]  MULTICAST_NET   = 4'hE;
	localparam logic [7:0]  PROTO_ICMP      = 8'd1;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [7:0]  PROTO_UDP       = 8'd17;
	localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
	localparam logic [7:0]  ICMP_CODE_NONE  = 8'd0;

	logic [16:0] len_ext;
	logic [16:0] ip_end;
	logic [16:0] udp_end;
	logic [15:0] udp_len;
	logic        bad_source;
	logic        frag_set;
	logic        rate_hit;
	logic [63:0] elapsed;

	assign len_ext    = {3'b0, info.len};
	assign ip_end     = {1'b0, info.total_length} + ETH_HDR_BYTES;
	assign udp_len    = info.l4_header[31:16];
	assign udp_end    = {1'b0, udp_len} + IP_END_BYTES;
	assign frag_set   = (info.frag_flags & FRAG_MF_MASK) != '0
		|| (info.frag_flags & FRAG_OFF_MASK) != '0;
	assign bad_source = info.src_addr == '0 || info.src_addr == '1
		|| info.src_addr == own_address || info.src_addr[31:24] == LOOPBACK_NET
		|| info.src_addr[31:28] == MULTICAST_NET;
	assign elapsed    = now_ticks - last_echo_tick;
	assign rate_hit   = elapsed < echo_min_interval;

	always_comb begin
		verdict_e v;
		v = VERDICT_BAD_PROTOCOL;
		result = '0;
		if (info.len < LEN_ETH) begin
			v = VERDICT_RUNT;
		end else if (info.len > LEN_MAX) begin
			v = VERDICT_OVERSIZED;
		end else if (info.ether_type == ETYPE_ARP) begin
			v = VERDICT_ARP;
		end else if (info.ether_type != ETYPE_IPV4) begin
			v = VERDICT_OTHER_ETYPE;
		end else if (info.len < LEN_IP || info.version_ihl[7:4] != IP_VERSION) begin
			v = VERDICT_RUNT;
		end else if (info.version_ihl[3:0] != IP_IHL_PLAIN) begin
			v = VERDICT_OPTIONS;
		end else if (info.total_length < IP_HDR_BYTES || ip_end > len_ext) begin
			v = VERDICT_RUNT;
		end else if (info.header_sum != 17'h0FFFF) begin
			v = VERDICT_BAD_CHECKSUM;
		end else if (frag_set) begin
			v = VERDICT_FRAGMENT;
		end else if (bad_source) begin
			v = VERDICT_BAD_SOURCE;
		end else if (info.time_to_live == '0) begin
			v = VERDICT_RUNT;
		end else if (info.dst_addr != own_address && info.dst_addr != '1) begin
			v = VERDICT_NOT_FOR_US;
		end else if (info.protocol_number == PROTO_ICMP) begin
			if (info.total_length < ICMP_MIN_TOTAL || ip_end > REPLY_LIMIT
				|| info.l4_header[63:56] != ICMP_ECHO_REQ
				|| info.l4_header[55:48] != ICMP_CODE_NONE) begin
				v = VERDICT_ICMP_IGNORED;
			end else if (rate_hit) begin
				v = VERDICT_ICMP_LIMITED;
			end else begin
				v = VERDICT_ECHO_REPLY;
				result.echo_taken = 1'b1;
			end
		end else if (info.protocol_number == PROTO_TCP) begin
			if (info.total_length > IP_HDR_BYTES) begin
				v = VERDICT_TCP_DELIVER;
				result.word.payload_length = COUNT_W'(info.total_length - IP_HDR_BYTES);
			end else begin
				v = VERDICT_TCP_EMPTY;
			end
		end else if (info.protocol_number == PROTO_UDP) begin
			if (info.len < LEN_UDP || udp_len < UDP_HDR_BYTES || udp_end > len_ext) begin
				v = VERDICT_UDP_MALFORMED;
			end else begin
				v = VERDICT_UDP_DELIVER;
				result.word.source_port    = info.l4_header[63:48];
				result.word.dest_port      = info.l4_header[47:32];
				result.word.payload_length = COUNT_W'(udp_len - UDP_HDR_BYTES);
			end
		end
		result.word.verdict = v;
		if (info.ether_type == ETYPE_IPV4 && info.len >= LEN_IP) begin
			result.word.source_address = info.src_addr;
		end
	end

endmodule

FILE: hw/rtl/ipv4_ingress_filter_core.sv
// IPv4 ingress filter: byte-wide frame input, one verdict word per frame.
//
// Input channel frame_valid / frame_ready / frame carries one frame byte per
// word, with end_of_frame on the last byte and now_ticks sampled there.
// Output channel result_valid / result_ready / result carries one verdict word
// per frame: verdict code, IPv4 source address, UDP ports, payload length.
// Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
// register 0 (own IPv4 address) and register 1 (minimum echo interval); other
// indexes are dropped. Write it only while no frame is in flight.
//
// Throughput: one byte per cycle while frame_ready is high, frames back to back,
// set by the per-byte capture register. After the clock edge that accepts the
// last byte, the verdict word passes the frame snapshot, then the verdict register.
// Reset clears the capture state, the registers and the last echo tick, and
// empties both pipeline stages.
// When the receiver stalls, the verdict word holds in the output register and
// one more finished frame can wait in the snapshot stage; frame_ready then
// drops until the output register drains.
module ipv4_ingress_filter_core import ipvf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   frame_valid,
	output logic                   frame_ready,
	input  in_word_t               frame,
	output logic                   result_valid,
	input  logic                   result_ready,
	output out_word_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic          frame_acc;
	logic          s1_adv;
	frame_info_t   frame_next;
	frame_info_t   info_s1;
	logic [63:0]   now_s1;
	logic          valid_s1;
	judge_result_t judged;
	logic          out_valid_q;
	out_word_t     out_q;
	logic [31:0]   own_address_q;
	logic [63:0]   echo_min_interval_q;
	logic [63:0]   last_echo_tick_q;

	// Snapshot moves on when the output register is empty or being drained.
	assign s1_adv      = valid_s1 && (!out_valid_q || result_ready);
	assign frame_ready = !valid_s1 || !out_valid_q || result_ready;
	assign frame_acc   = frame_valid && frame_ready;
	assign cfg_ready   = 1'b1;

	ipvf_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (frame_acc),
		.word       (frame),
		.frame_next (frame_next)
	);

	ipvf_judge u_judge (
		.info              (info_s1),
		.now_ticks         (now_s1),
		.own_address       (own_address_q),
		.echo_min_interval (echo_min_interval_q),
		.last_echo_tick    (last_echo_tick_q),
		.result            (judged)
	);

	// Hold the finished frame, including its last byte, for the verdict stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_acc && frame.end_of_frame) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc && frame.end_of_frame) begin
			info_s1 <= frame_next;
			now_s1  <= frame.now_ticks;
		end
	end

	// Output register: load on advance, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= judged.word;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Advance the echo tick only when an echo request passes the rate limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_echo_tick_q <= '0;
		end else if (s1_adv && judged.echo_taken) begin
			last_echo_tick_q <= now_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q       <= '0;
			echo_min_interval_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OWN_ADDRESS:       own_address_q       <= cfg_data[31:0];
				CFG_ECHO_MIN_INTERVAL: echo_min_interval_q <= cfg_data;
				default:               ;
			endcase
		end
	end

	// A full snapshot behind a stalled output must block new bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result_ready) |-> !frame_ready)
		else $error("frame accepted while both verdict stages are stalled");

	// The echo tick moves only together with an echo reply verdict.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_echo_tick_q) |->
			(result_valid && result.verdict == VERDICT_ECHO_REPLY))
		else $error("echo tick changed without an echo reply verdict");

	// A new verdict word comes only from a held frame snapshot.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("verdict word raised without a frame snapshot");

endmodule
